>>> rtl/tljaq_pkg.sv
// shared types and constants for the two-level job admission queue
// used by tljaq_ctrl, tljaq_dp and two_level_job_admission_queue
package tljaq_pkg;

  // request kinds
  localparam logic [1:0] KIND_SUBMIT = 2'd0;
  localparam logic [1:0] KIND_TAKE   = 2'd1;
  localparam logic [1:0] KIND_LIST   = 2'd2;
  localparam logic [1:0] KIND_REMOVE = 2'd3;

  // job type that is never accepted
  localparam logic [1:0] TYPE_BAD = 2'd3;

  // most results a list may report
  localparam logic [3:0] LIST_MAX = 4'd8;
  localparam logic [3:0] EXTRA_SAT = 4'd15;

  // result status codes
  localparam logic [3:0] ST_QUEUED     = 4'd0;
  localparam logic [3:0] ST_PARKED     = 4'd1;
  localparam logic [3:0] ST_BUSY       = 4'd2;
  localparam logic [3:0] ST_INVALID    = 4'd3;
  localparam logic [3:0] ST_EMPTY      = 4'd4;
  localparam logic [3:0] ST_DISPATCHED = 4'd5;
  localparam logic [3:0] ST_REMOVED    = 4'd6;
  localparam logic [3:0] ST_NOT_FOUND  = 4'd7;
  localparam logic [3:0] ST_LISTED     = 4'd8;

  typedef struct packed {
    logic [21:0] owner;
    logic [31:0] job;
    logic [1:0]  jtype;
  } entry_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [21:0] owner_id;
    logic [31:0] job_id;
    logic [1:0]  job_class;
    logic [3:0]  list_limit;
  } req_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [21:0] entry_owner;
    logic [31:0] entry_job;
    logic [1:0]  entry_type;
    logic        entry_valid;
    logic [21:0] woken_owner;
    logic        woken_valid;
    logic [3:0]  extra_count;
    logic        last;
  } rsp_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAP,
    OP_SUBMIT,
    OP_TAKE,
    OP_COUNT,
    OP_NEXT,
    OP_SHIFT,
    OP_REMOVED,
    OP_NOTFOUND,
    OP_LIST_NONE,
    OP_RESTART,
    OP_LIST_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   rd_next;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       owner_match;
    logic       full_match;
    logic       scan_end;
    logic       shift_end;
    logic       out_free;
    logic       nrep_zero;
    logic       emit_last;
  } dp_sts_t;

endpackage

>>> rtl/tljaq_dp.sv
// datapath: pending and sleeping circular stores, scan index, counters, result register
// depends on tljaq_pkg
module tljaq_dp #(
  parameter int PD = 8,
  parameter int SD = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  tljaq_pkg::dp_cmd_t cmd,
  input  tljaq_pkg::req_t   req,
  output tljaq_pkg::dp_sts_t sts,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output tljaq_pkg::rsp_t   rsp
);

  localparam int PAW = (PD > 1) ? $clog2(PD) : 1;
  localparam int PCW = $clog2(PD + 1);
  localparam int SAW = (SD > 1) ? $clog2(SD) : 1;
  localparam int SCW = $clog2(SD + 1);
  localparam int TW  = (PCW > 4) ? PCW : 4;

  // circular index helpers, base below depth and offset at most depth
  function automatic logic [PAW-1:0] p_wrap(input logic [PAW-1:0] b, input logic [PCW:0] o);
    logic [PCW:0] s;
    s = (PCW+1)'(b) + o;
    if (s >= (PCW+1)'(PD)) s = s - (PCW+1)'(PD);
    return s[PAW-1:0];
  endfunction

  function automatic logic [SAW-1:0] s_wrap(input logic [SAW-1:0] b, input logic [SCW:0] o);
    logic [SCW:0] s;
    s = (SCW+1)'(b) + o;
    if (s >= (SCW+1)'(SD)) s = s - (SCW+1)'(SD);
    return s[SAW-1:0];
  endfunction

  tljaq_pkg::req_t   q, q_next;
  logic [PAW-1:0]    p_head, p_head_next;
  logic [PCW-1:0]    p_cnt, p_cnt_next;
  logic [SAW-1:0]    s_head, s_head_next;
  logic [SCW-1:0]    s_cnt, s_cnt_next;
  logic [PCW-1:0]    idx, idx_next;
  logic [PCW-1:0]    total, total_next;
  logic [3:0]        emitted, emitted_next;

  tljaq_pkg::entry_t pmem [PD];
  tljaq_pkg::entry_t smem [SD];
  tljaq_pkg::entry_t p_q, s_q;

  logic [PAW-1:0]    pr_addr, pw_addr, p_tail;
  logic [SAW-1:0]    s_tail;
  logic              pw_en, sw_en;
  tljaq_pkg::entry_t pw_data, new_entry;

  logic              ld;
  tljaq_pkg::rsp_t   r_next;

  logic [3:0]        lim, nrep, extra;
  logic [TW-1:0]     tot_w, diff;

  assign pr_addr = p_wrap(p_head, (PCW+1)'(idx) + (PCW+1)'(cmd.rd_next));
  assign p_tail  = p_wrap(p_head, (PCW+1)'(p_cnt));
  assign s_tail  = s_wrap(s_head, (SCW+1)'(s_cnt));
  assign new_entry = '{owner: q.owner_id, job: q.job_id, jtype: q.job_class};

  // list bookkeeping
  always_comb begin
    lim   = (q.list_limit > tljaq_pkg::LIST_MAX) ? tljaq_pkg::LIST_MAX : q.list_limit;
    tot_w = TW'(total);
    nrep  = (tot_w > TW'(lim)) ? lim : tot_w[3:0];
    diff  = tot_w - TW'(nrep);
    extra = (diff > TW'(tljaq_pkg::EXTRA_SAT)) ? tljaq_pkg::EXTRA_SAT : diff[3:0];
  end

  // status back to the controller
  always_comb begin
    sts.kind        = q.kind;
    sts.owner_match = (p_q.owner == q.owner_id);
    sts.full_match  = (p_q.owner == q.owner_id) && (p_q.job == q.job_id);
    sts.scan_end    = (idx == p_cnt);
    sts.shift_end   = ((PCW+1)'(idx) + (PCW+1)'(1)) == (PCW+1)'(p_cnt);
    sts.out_free    = !rsp_valid || !rsp_stall;
    sts.nrep_zero   = (nrep == 4'd0);
    sts.emit_last   = ((emitted + 4'd1) == nrep);
  end

  // operation decode
  always_comb begin
    q_next       = q;
    p_head_next  = p_head;
    p_cnt_next   = p_cnt;
    s_head_next  = s_head;
    s_cnt_next   = s_cnt;
    idx_next     = idx;
    total_next   = total;
    emitted_next = emitted;
    pw_en        = 1'b0;
    pw_addr      = p_tail;
    pw_data      = new_entry;
    sw_en        = 1'b0;
    ld           = 1'b0;
    r_next       = '0;
    r_next.last  = 1'b1;
    case (cmd.op)
      tljaq_pkg::OP_CAP: begin
        q_next       = req;
        idx_next     = '0;
        total_next   = '0;
        emitted_next = '0;
      end
      tljaq_pkg::OP_SUBMIT: begin
        ld = 1'b1;
        if (q.owner_id == 22'd0 || q.job_class == tljaq_pkg::TYPE_BAD) begin
          r_next.status = tljaq_pkg::ST_INVALID;
        end else if (p_cnt < PCW'(PD)) begin
          pw_en         = 1'b1;
          p_cnt_next    = p_cnt + PCW'(1);
          r_next.status = tljaq_pkg::ST_QUEUED;
        end else if (s_cnt < SCW'(SD)) begin
          sw_en         = 1'b1;
          s_cnt_next    = s_cnt + SCW'(1);
          r_next.status = tljaq_pkg::ST_PARKED;
        end else begin
          r_next.status = tljaq_pkg::ST_BUSY;
        end
      end
      tljaq_pkg::OP_TAKE: begin
        ld = 1'b1;
        if (p_cnt == '0) begin
          r_next.status = tljaq_pkg::ST_EMPTY;
        end else begin
          r_next.status      = tljaq_pkg::ST_DISPATCHED;
          r_next.entry_owner = p_q.owner;
          r_next.entry_job   = p_q.job;
          r_next.entry_type  = p_q.jtype;
          r_next.entry_valid = 1'b1;
          p_head_next        = p_wrap(p_head, (PCW+1)'(1));
          if (s_cnt != '0) begin
            // promote sleeping head into the slot behind the tail
            pw_en              = 1'b1;
            pw_data            = s_q;
            s_head_next        = s_wrap(s_head, (SCW+1)'(1));
            s_cnt_next         = s_cnt - SCW'(1);
            r_next.woken_owner = s_q.owner;
            r_next.woken_valid = 1'b1;
          end else begin
            p_cnt_next = p_cnt - PCW'(1);
          end
        end
      end
      tljaq_pkg::OP_COUNT: begin
        if (p_q.owner == q.owner_id) total_next = total + PCW'(1);
        idx_next = idx + PCW'(1);
      end
      tljaq_pkg::OP_NEXT: begin
        idx_next = idx + PCW'(1);
      end
      tljaq_pkg::OP_SHIFT: begin
        pw_en    = 1'b1;
        pw_addr  = p_wrap(p_head, (PCW+1)'(idx));
        pw_data  = p_q;
        idx_next = idx + PCW'(1);
      end
      tljaq_pkg::OP_REMOVED: begin
        ld            = 1'b1;
        p_cnt_next    = p_cnt - PCW'(1);
        r_next.status = tljaq_pkg::ST_REMOVED;
      end
      tljaq_pkg::OP_NOTFOUND: begin
        ld            = 1'b1;
        r_next.status = tljaq_pkg::ST_NOT_FOUND;
      end
      tljaq_pkg::OP_LIST_NONE: begin
        ld                 = 1'b1;
        r_next.status      = tljaq_pkg::ST_LISTED;
        r_next.extra_count = extra;
      end
      tljaq_pkg::OP_RESTART: begin
        idx_next = '0;
      end
      tljaq_pkg::OP_LIST_EMIT: begin
        ld                 = 1'b1;
        r_next.status      = tljaq_pkg::ST_LISTED;
        r_next.entry_owner = p_q.owner;
        r_next.entry_job   = p_q.job;
        r_next.entry_type  = p_q.jtype;
        r_next.entry_valid = 1'b1;
        r_next.extra_count = extra;
        r_next.last        = sts.emit_last;
        emitted_next       = emitted + 4'd1;
        idx_next           = idx + PCW'(1);
      end
      default: begin
      end
    endcase
  end

  // stores, read data registered
  always_ff @(posedge clk) begin
    if (pw_en) pmem[pw_addr] <= pw_data;
    p_q <= pmem[pr_addr];
  end

  always_ff @(posedge clk) begin
    if (sw_en) smem[s_tail] <= new_entry;
    s_q <= smem[s_head];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      p_head    <= '0;
      p_cnt     <= '0;
      s_head    <= '0;
      s_cnt     <= '0;
      idx       <= '0;
      total     <= '0;
      emitted   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      p_head  <= p_head_next;
      p_cnt   <= p_cnt_next;
      s_head  <= s_head_next;
      s_cnt   <= s_cnt_next;
      idx     <= idx_next;
      total   <= total_next;
      emitted <= emitted_next;
      if (ld) rsp_valid <= 1'b1;
      else if (!rsp_stall) rsp_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    q <= q_next;
    if (ld) rsp <= r_next;
  end

endmodule

>>> rtl/tljaq_ctrl.sv
// controller: sequences submit, take, scan, shift and list passes
// depends on tljaq_pkg
module tljaq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  tljaq_pkg::dp_sts_t sts,
  output tljaq_pkg::dp_cmd_t cmd
);

  typedef enum logic [11:0] {
    S_IDLE      = 12'b000000000001,
    S_DECODE    = 12'b000000000010,
    S_SUBMIT    = 12'b000000000100,
    S_TAKE      = 12'b000000001000,
    S_SCAN      = 12'b000000010000,
    S_SCAN_WAIT = 12'b000000100000,
    S_SHIFT     = 12'b000001000000,
    S_SHIFT_WR  = 12'b000010000000,
    S_RM_DONE   = 12'b000100000000,
    S_LIST_MID  = 12'b001000000000,
    S_LIST_WAIT = 12'b010000000000,
    S_LIST2     = 12'b100000000000
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next  = state;
    cmd.op      = tljaq_pkg::OP_NONE;
    cmd.rd_next = 1'b0;
    req_stall   = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.op     = tljaq_pkg::OP_CAP;
          state_next = S_DECODE;
        end
      end
      // read of the first pending entry is under way here
      S_DECODE: begin
        if (sts.kind == tljaq_pkg::KIND_SUBMIT) state_next = S_SUBMIT;
        else if (sts.kind == tljaq_pkg::KIND_TAKE) state_next = S_TAKE;
        else state_next = S_SCAN;
      end
      S_SUBMIT: begin
        if (sts.out_free) begin
          cmd.op     = tljaq_pkg::OP_SUBMIT;
          state_next = S_IDLE;
        end
      end
      S_TAKE: begin
        if (sts.out_free) begin
          cmd.op     = tljaq_pkg::OP_TAKE;
          state_next = S_IDLE;
        end
      end
      // walk of pending entries for remove and the list count pass
      S_SCAN: begin
        if (sts.scan_end) begin
          if (sts.kind == tljaq_pkg::KIND_REMOVE) begin
            if (sts.out_free) begin
              cmd.op     = tljaq_pkg::OP_NOTFOUND;
              state_next = S_IDLE;
            end
          end else begin
            state_next = S_LIST_MID;
          end
        end else if (sts.kind == tljaq_pkg::KIND_REMOVE) begin
          if (sts.full_match) begin
            state_next = S_SHIFT;
          end else begin
            cmd.op     = tljaq_pkg::OP_NEXT;
            state_next = S_SCAN_WAIT;
          end
        end else begin
          cmd.op     = tljaq_pkg::OP_COUNT;
          state_next = S_SCAN_WAIT;
        end
      end
      S_SCAN_WAIT: begin
        state_next = S_SCAN;
      end
      // close the gap one entry at a time
      S_SHIFT: begin
        if (sts.shift_end) begin
          state_next = S_RM_DONE;
        end else begin
          cmd.rd_next = 1'b1;
          state_next  = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        cmd.op     = tljaq_pkg::OP_SHIFT;
        state_next = S_SHIFT;
      end
      S_RM_DONE: begin
        if (sts.out_free) begin
          cmd.op     = tljaq_pkg::OP_REMOVED;
          state_next = S_IDLE;
        end
      end
      S_LIST_MID: begin
        if (sts.nrep_zero) begin
          if (sts.out_free) begin
            cmd.op     = tljaq_pkg::OP_LIST_NONE;
            state_next = S_IDLE;
          end
        end else begin
          cmd.op     = tljaq_pkg::OP_RESTART;
          state_next = S_LIST_WAIT;
        end
      end
      S_LIST_WAIT: begin
        state_next = S_LIST2;
      end
      // report pass over the matches
      S_LIST2: begin
        if (sts.owner_match) begin
          if (sts.out_free) begin
            cmd.op     = tljaq_pkg::OP_LIST_EMIT;
            state_next = sts.emit_last ? S_IDLE : S_LIST_WAIT;
          end
        end else begin
          cmd.op     = tljaq_pkg::OP_NEXT;
          state_next = S_LIST_WAIT;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

endmodule

>>> rtl/two_level_job_admission_queue.sv
// two-level job admission queue, one request at a time, results in a holding register
// submit and take: capture, decode, then any wait on the result side before execution;
// remove: scan then shift; list: count pass then report pass; the pace of each walk
// set by the single registered read port of the pending store walked by the scan index
// synchronous reset empties both queues; store contents are not cleared
// depends on tljaq_pkg, tljaq_ctrl, tljaq_dp
module two_level_job_admission_queue #(
  parameter int PENDING_DEPTH = 8,
  parameter int SLEEP_DEPTH   = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  tljaq_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_stall,
  output tljaq_pkg::rsp_t rsp
);

  tljaq_pkg::dp_cmd_t cmd;
  tljaq_pkg::dp_sts_t sts;

  tljaq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  tljaq_dp #(
    .PD (PENDING_DEPTH),
    .SD (SLEEP_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req       (req),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

>>> tb/tb_top.sv
// testbench for the two-level job admission queue: directed and random requests
// results checked against an in-bench model of the pending and sleeping queues
// depends on tljaq_pkg and two_level_job_admission_queue
module tb_top;

  localparam int PDEPTH = 8;
  localparam int SDEPTH = 8;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  tljaq_pkg::req_t req;
  logic rsp_valid;
  logic rsp_stall;
  tljaq_pkg::rsp_t rsp;

  // model state
  tljaq_pkg::entry_t pend_q[$];
  tljaq_pkg::entry_t sleep_q[$];
  tljaq_pkg::rsp_t   want_q[$];
  int     errors;
  bit     stall_on;
  bit     idle_on;
  int     stall_left;

  two_level_job_admission_queue #(
    .PENDING_DEPTH(PDEPTH),
    .SLEEP_DEPTH(SDEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic tljaq_pkg::rsp_t blank_rsp(logic [3:0] st);
    tljaq_pkg::rsp_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  // work out the results of one request and update the queue model
  task automatic queue_predict(tljaq_pkg::req_t r);
    tljaq_pkg::rsp_t   o;
    tljaq_pkg::entry_t e;
    tljaq_pkg::entry_t hd;
    tljaq_pkg::entry_t hits[$];
    int     lim;
    int     extra;
    int     pos;
    e.owner = r.owner_id;
    e.job = r.job_id;
    e.jtype = r.job_class;
    case (r.kind)
      tljaq_pkg::KIND_SUBMIT: begin
        if (r.owner_id == 22'd0 || r.job_class == tljaq_pkg::TYPE_BAD) begin
          want_q.push_back(blank_rsp(tljaq_pkg::ST_INVALID));
        end else if (pend_q.size() < PDEPTH) begin
          pend_q.push_back(e);
          want_q.push_back(blank_rsp(tljaq_pkg::ST_QUEUED));
        end else if (sleep_q.size() < SDEPTH) begin
          sleep_q.push_back(e);
          want_q.push_back(blank_rsp(tljaq_pkg::ST_PARKED));
        end else begin
          want_q.push_back(blank_rsp(tljaq_pkg::ST_BUSY));
        end
      end
      tljaq_pkg::KIND_TAKE: begin
        if (pend_q.size() == 0) begin
          want_q.push_back(blank_rsp(tljaq_pkg::ST_EMPTY));
        end else begin
          hd = pend_q.pop_front();
          o = blank_rsp(tljaq_pkg::ST_DISPATCHED);
          o.entry_owner = hd.owner;
          o.entry_job = hd.job;
          o.entry_type = hd.jtype;
          o.entry_valid = 1'b1;
          if (sleep_q.size() > 0) begin
            hd = sleep_q.pop_front();
            pend_q.push_back(hd);
            o.woken_owner = hd.owner;
            o.woken_valid = 1'b1;
          end
          want_q.push_back(o);
        end
      end
      tljaq_pkg::KIND_LIST: begin
        lim = (r.list_limit > tljaq_pkg::LIST_MAX) ? int'(tljaq_pkg::LIST_MAX) :
                                                      int'(r.list_limit);
        extra = 0;
        foreach (pend_q[i]) begin
          if (pend_q[i].owner == r.owner_id) begin
            if (hits.size() < lim) hits.push_back(pend_q[i]);
            else extra++;
          end
        end
        if (extra > int'(tljaq_pkg::EXTRA_SAT)) extra = int'(tljaq_pkg::EXTRA_SAT);
        if (hits.size() == 0) begin
          o = blank_rsp(tljaq_pkg::ST_LISTED);
          o.extra_count = 4'(extra);
          want_q.push_back(o);
        end else begin
          foreach (hits[k]) begin
            o = blank_rsp(tljaq_pkg::ST_LISTED);
            o.entry_owner = hits[k].owner;
            o.entry_job = hits[k].job;
            o.entry_type = hits[k].jtype;
            o.entry_valid = 1'b1;
            o.extra_count = 4'(extra);
            o.last = (k == hits.size() - 1);
            want_q.push_back(o);
          end
        end
      end
      default: begin
        pos = -1;
        foreach (pend_q[i]) begin
          if (pos < 0 && pend_q[i].owner == r.owner_id && pend_q[i].job == r.job_id)
            pos = i;
        end
        if (pos >= 0) begin
          pend_q.delete(pos);
          want_q.push_back(blank_rsp(tljaq_pkg::ST_REMOVED));
        end else begin
          want_q.push_back(blank_rsp(tljaq_pkg::ST_NOT_FOUND));
        end
      end
    endcase
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  // send one request, with optional idle burst before it
  task automatic send_req(tljaq_pkg::req_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    queue_predict(r);
  endtask

  function automatic tljaq_pkg::req_t mk_req(logic [1:0] k, logic [21:0] o, logic [31:0] j,
                                             logic [1:0] t, logic [3:0] l);
    tljaq_pkg::req_t r;
    r.kind = k;
    r.owner_id = o;
    r.job_id = j;
    r.job_class = t;
    r.list_limit = l;
    return r;
  endfunction

  // random result side stall bursts
  always @(posedge clk) begin
    if (rst || !stall_on) begin
      rsp_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      rsp_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!rsp_stall && $urandom_range(0, 4) == 0) begin
      rsp_stall  <= 1'b1;
      stall_left <= int'($urandom_range(0, 2));
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    tljaq_pkg::rsp_t w;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (want_q.size() == 0) begin
        report_mismatch("unexpected result", 64'(rsp.status), 64'(0));
      end else begin
        w = want_q.pop_front();
        if (rsp.status != w.status)
          report_mismatch("status", 64'(rsp.status), 64'(w.status));
        if (rsp.entry_owner != w.entry_owner)
          report_mismatch("entry_owner", 64'(rsp.entry_owner), 64'(w.entry_owner));
        if (rsp.entry_job != w.entry_job)
          report_mismatch("entry_job", 64'(rsp.entry_job), 64'(w.entry_job));
        if (rsp.entry_type != w.entry_type)
          report_mismatch("entry_type", 64'(rsp.entry_type), 64'(w.entry_type));
        if (rsp.entry_valid != w.entry_valid)
          report_mismatch("entry_valid", 64'(rsp.entry_valid), 64'(w.entry_valid));
        if (rsp.woken_owner != w.woken_owner)
          report_mismatch("woken_owner", 64'(rsp.woken_owner), 64'(w.woken_owner));
        if (rsp.woken_valid != w.woken_valid)
          report_mismatch("woken_valid", 64'(rsp.woken_valid), 64'(w.woken_valid));
        if (rsp.extra_count != w.extra_count)
          report_mismatch("extra_count", 64'(rsp.extra_count), 64'(w.extra_count));
        if (rsp.last != w.last)
          report_mismatch("last", 64'(rsp.last), 64'(w.last));
      end
    end
  end

  // invalid submits, empty take, miss on remove, empty list
  task automatic test_special_cases();
    send_req(mk_req(tljaq_pkg::KIND_TAKE, 22'd5, 32'd0, 2'd0, 4'd0));
    send_req(mk_req(tljaq_pkg::KIND_SUBMIT, 22'd0, 32'hFFFF_FFFF, 2'd1, 4'd0));
    send_req(mk_req(tljaq_pkg::KIND_SUBMIT, 22'h3FFFFF, 32'd1, tljaq_pkg::TYPE_BAD, 4'hF));
    send_req(mk_req(tljaq_pkg::KIND_REMOVE, 22'h3FFFFF, 32'd1, 2'd0, 4'd0));
    send_req(mk_req(tljaq_pkg::KIND_LIST, 22'h3FFFFF, 32'd0, 2'd0, 4'hF));
  endtask

  // fill both queues past capacity, list with limits, remove, then take three jobs
  task automatic test_fill_and_drain();
    for (int i = 0; i < 17; i++)
      send_req(mk_req(tljaq_pkg::KIND_SUBMIT, (i % 2 != 0) ? 22'h3FFFFF : 22'd1,
                      32'hFFFF_FFF0 + 32'(i), 2'(i % 3), 4'd0));
    send_req(mk_req(tljaq_pkg::KIND_LIST, 22'd1, 32'd0, 2'd0, 4'hF));
    send_req(mk_req(tljaq_pkg::KIND_LIST, 22'h3FFFFF, 32'd0, 2'd0, 4'd1));
    send_req(mk_req(tljaq_pkg::KIND_LIST, 22'd1, 32'd0, 2'd0, 4'd0));
    send_req(mk_req(tljaq_pkg::KIND_REMOVE, 22'h3FFFFF, 32'hFFFF_FFF1, 2'd0, 4'd0));
    for (int i = 0; i < 3; i++)
      send_req(mk_req(tljaq_pkg::KIND_TAKE, 22'd0, 32'd0, 2'd0, 4'd0));
  endtask

  // random requests over a small owner set so lists and removes hit
  task automatic test_random(int n);
    tljaq_pkg::req_t r;
    logic [63:0]     bits;
    for (int i = 0; i < n; i++) begin
      bits = {$urandom, $urandom};
      r = bits[61:0];
      if ($urandom_range(0, 9) != 0) begin
        r.owner_id = 22'($urandom_range(1, 3));
        if ($urandom_range(0, 9) == 0) r.owner_id = 22'h3FFFFF;
        if ($urandom_range(0, 1) != 0) r.job_id = $urandom_range(0, 7);
        if (r.kind == tljaq_pkg::KIND_REMOVE && pend_q.size() > 0 &&
            $urandom_range(0, 1) != 0) begin
          int p;
          p = int'($urandom_range(0, pend_q.size() - 1));
          r.owner_id = pend_q[p].owner;
          r.job_id = pend_q[p].job;
        end
        if ($urandom_range(0, 7) != 0 && r.job_class == tljaq_pkg::TYPE_BAD)
          r.job_class = 2'd1;
      end
      send_req(r);
    end
  endtask

  initial begin
    errors = 0;
    stall_on = 0;
    idle_on = 0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    stall_on = 1;
    idle_on = 1;
    test_special_cases();
    test_fill_and_drain();
    test_random(130);
    stall_on = 0;
    idle_on = 0;
    test_random(25);
    req_valid <= 1'b0;
    while (want_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("PASS two_level_job_admission_queue");
    end else begin
      $display("FAIL two_level_job_admission_queue");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("FAIL two_level_job_admission_queue");
    $finish;
  end

endmodule

>>> two_level_job_admission_queue.f
rtl/tljaq_pkg.sv
rtl/tljaq_dp.sv
rtl/tljaq_ctrl.sv
rtl/two_level_job_admission_queue.sv
tb/tb_top.sv
